// ===== hdl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, token codes, character constants and literal tables for the
// JSON byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int TOK_W           = 16;
    localparam int QUEUE_DEPTH     = 4;

    // token kinds
    localparam logic [3:0] TK_EOF      = 4'd0;
    localparam logic [3:0] TK_LBRACE   = 4'd1;
    localparam logic [3:0] TK_RBRACE   = 4'd2;
    localparam logic [3:0] TK_STRING   = 4'd3;
    localparam logic [3:0] TK_NUMBER   = 4'd4;
    localparam logic [3:0] TK_BOOLEAN  = 4'd5;
    localparam logic [3:0] TK_NULL     = 4'd6;
    localparam logic [3:0] TK_COLON    = 4'd7;
    localparam logic [3:0] TK_COMMA    = 4'd8;
    localparam logic [3:0] TK_LBRACKET = 4'd9;
    localparam logic [3:0] TK_RBRACKET = 4'd10;
    localparam logic [3:0] TK_ERROR    = 4'd11;

    // literal kinds
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2c;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3a;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_RBRACKET = 8'h5d;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6e;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_LBRACE   = 8'h7b;
    localparam logic [7:0] CH_RBRACE   = 8'h7d;

    localparam logic [39:0] TXT_TRUE  = {"true", 8'h00};
    localparam logic [39:0] TXT_FALSE = "false";
    localparam logic [39:0] TXT_NULL  = {"null", 8'h00};

    typedef struct packed {
        logic [3:0]       token_kind;
        logic [TOK_W-1:0] token_offset;
        logic [TOK_W-1:0] token_length;
        logic             bool_value;
        logic             offset_overflow;
        logic             last_of_run;
    } token_t;

    // tokens produced by one byte, in order
    typedef struct packed {
        token_t [1:0] tok;
        logic   [1:0] cnt;
    } scan_res_t;

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        len = (kind == LIT_FALSE) ? 3'd5 : 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [39:0] txt;
        logic [7:0]  ch;
        case (kind)
            LIT_TRUE:  txt = TXT_TRUE;
            LIT_FALSE: txt = TXT_FALSE;
            default:   txt = TXT_NULL;
        endcase
        case (idx)
            3'd0:    ch = txt[39:32];
            3'd1:    ch = txt[31:24];
            3'd2:    ch = txt[23:16];
            3'd3:    ch = txt[15:8];
            3'd4:    ch = txt[7:0];
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/jbt_if.sv =====
// ----------------------------------------------------------------------------
// jbt channel interfaces
// Valid/ready channels for document bytes in and tokens out.
// ----------------------------------------------------------------------------
interface text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        bool_value;
    logic        offset_overflow;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output bool_value, output offset_overflow,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_length, input bool_value, input offset_overflow,
                    input last_of_run, output ready);
endinterface

// ===== hdl/json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON lexer: one document byte per item in, tokens out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | items
//  text    | in  | text_byte                                        | 1 per byte
//  token   | out | token_kind, token_offset, token_length,          | 0..2 per byte
//          |     | bool_value, offset_overflow, last_of_run         |
//
// one byte per cycle while text.ready is high; a byte is decoded in the cycle
// after it is taken and its tokens are registered into a four-entry output
// queue. a byte that yields two tokens writes both into the queue at once.
// text.ready is low while the queue could not absorb two more tokens.
// reset clears the lexer state, the offset counter and the queue.
module json_byte_tokenizer
    import jbt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    text_if.sink     text,
    token_if.source  token
);

    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    scan_res_t        res;
    logic             load;
    logic             pop;
    logic [QW-1:0]    cnt_reg, cnt_next;
    logic [QW-1:0]    base;
    token_t           q_reg  [QUEUE_DEPTH];
    token_t           q_next [QUEUE_DEPTH];

    jbt_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .text_byte (text.text_byte),
        .res       (res)
    );

    // room for two more tokens after the byte now being decoded
    assign text.ready = (cnt_reg + QW'(res.cnt)) <= QW'(QUEUE_DEPTH - 2);
    assign load       = text.valid && text.ready;

    assign token.valid = (cnt_reg != '0);
    assign pop         = token.valid && token.ready;
    assign base        = cnt_reg - QW'(pop);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        if (res.cnt != 2'd0)
        begin
            q_next[IW'(base)] = res.tok[0];
        end
        if (res.cnt == 2'd2)
        begin
            q_next[IW'(base + QW'(1))] = res.tok[1];
        end
        cnt_next = base + QW'(res.cnt);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign token.token_kind      = q_reg[0].token_kind;
    assign token.token_offset    = q_reg[0].token_offset;
    assign token.token_length    = q_reg[0].token_length;
    assign token.bool_value      = q_reg[0].bool_value;
    assign token.offset_overflow = q_reg[0].offset_overflow;
    assign token.last_of_run     = q_reg[0].last_of_run;

endmodule

// ===== hdl/jbt_scan.sv =====
// ----------------------------------------------------------------------------
// jbt_scan
// Input byte register and lexer state; produces up to two tokens per byte
// in the cycle after the byte is loaded.
// ----------------------------------------------------------------------------
module jbt_scan
    import jbt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [7:0] text_byte,
    output scan_res_t  res
);

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_LITERAL = 2'd3;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    logic [7:0]             byte_reg;
    logic                   vld_reg;
    logic [1:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [1:0]             lk_reg, lk_next;
    logic [2:0]             li_reg, li_next;
    logic                   sat_reg, sat_next;

    logic [OFFSET_BITS-1:0] span;
    logic                   is_digit;
    logic                   at_max;

    // idle-path decode
    logic                   id_emit;
    logic [3:0]             id_kind;
    logic [TOK_W-1:0]       id_len;
    logic [1:0]             id_mode;
    logic [OFFSET_BITS-1:0] id_ts;
    logic [1:0]             id_lk;
    logic [2:0]             id_li;

    // pending-token path
    logic                   main_emit;
    logic [3:0]             main_kind;
    logic [TOK_W-1:0]       main_len;
    logic                   main_bool;
    logic                   run_idle;
    logic                   lit_hit;
    logic [2:0]             li_inc;
    logic                   idle_out;
    logic [1:0]             mode_step;
    token_t                 main_tok, idle_tok;

    assign span     = (off_reg >= ts_reg) ? (off_reg - ts_reg) : '0;
    assign is_digit = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign at_max   = (off_reg == OFF_MAX);
    assign lit_hit  = (li_reg < lit_len(lk_reg)) && (byte_reg == lit_char(lk_reg, li_reg));
    assign li_inc   = li_reg + 3'd1;

    always_comb
    begin
        id_emit = 1'b0;
        id_kind = TK_ERROR;
        id_len  = TOK_W'(1);
        id_mode = MODE_IDLE;
        id_ts   = ts_reg;
        id_lk   = lk_reg;
        // a broken literal clears its match count before the byte is rescanned
        id_li   = (mode_reg == MODE_LITERAL) ? 3'd0 : li_reg;
        case (byte_reg)
            CH_NUL:
            begin
                id_emit = 1'b1;
                id_kind = TK_EOF;
                id_len  = '0;
            end
            CH_SPACE, CH_CR, CH_LF:
            begin
                id_emit = 1'b0;
            end
            CH_LBRACE:
            begin
                id_emit = 1'b1;
                id_kind = TK_LBRACE;
            end
            CH_RBRACE:
            begin
                id_emit = 1'b1;
                id_kind = TK_RBRACE;
            end
            CH_COLON:
            begin
                id_emit = 1'b1;
                id_kind = TK_COLON;
            end
            CH_COMMA:
            begin
                id_emit = 1'b1;
                id_kind = TK_COMMA;
            end
            CH_LBRACKET:
            begin
                id_emit = 1'b1;
                id_kind = TK_LBRACKET;
            end
            CH_RBRACKET:
            begin
                id_emit = 1'b1;
                id_kind = TK_RBRACKET;
            end
            CH_QUOTE:
            begin
                id_mode = MODE_STRING;
                id_ts   = at_max ? off_reg : (off_reg + OFF_ONE);
            end
            CH_T, CH_F, CH_N:
            begin
                id_mode = MODE_LITERAL;
                id_lk   = (byte_reg == CH_T) ? LIT_TRUE :
                          (byte_reg == CH_F) ? LIT_FALSE : LIT_NULL;
                id_li   = 3'd1;
                id_ts   = off_reg;
            end
            default:
            begin
                if (is_digit || (byte_reg == CH_MINUS))
                begin
                    id_mode = MODE_NUMBER;
                    id_ts   = off_reg;
                end
                else
                begin
                    id_emit = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        main_emit = 1'b0;
        main_kind = TK_ERROR;
        main_len  = TOK_W'(span);
        main_bool = 1'b0;
        run_idle  = 1'b0;
        mode_step = mode_reg;
        ts_next   = ts_reg;
        lk_next   = lk_reg;
        li_next   = li_reg;
        case (mode_reg)
            MODE_STRING:
            begin
                if (byte_reg == CH_QUOTE)
                begin
                    main_emit = 1'b1;
                    main_kind = TK_STRING;
                    mode_step = MODE_IDLE;
                end
                else if (byte_reg == CH_NUL)
                begin
                    main_emit = 1'b1;
                    run_idle  = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!is_digit)
                begin
                    main_emit = 1'b1;
                    main_kind = TK_NUMBER;
                    run_idle  = 1'b1;
                end
            end
            MODE_LITERAL:
            begin
                if (lit_hit)
                begin
                    li_next = li_inc;
                    if (li_inc == lit_len(lk_reg))
                    begin
                        main_emit = 1'b1;
                        main_kind = lk_reg[1] ? TK_NULL : TK_BOOLEAN;
                        main_len  = TOK_W'(li_inc);
                        main_bool = (lk_reg == LIT_TRUE);
                        mode_step = MODE_IDLE;
                        li_next   = 3'd0;
                    end
                end
                else
                begin
                    main_emit = 1'b1;
                    main_len  = TOK_W'(li_reg);
                    run_idle  = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase
        if (run_idle)
        begin
            mode_step = id_mode;
            ts_next   = id_ts;
            lk_next   = id_lk;
            li_next   = id_li;
        end
    end

    // offset counter; a zero byte starts a new document
    always_comb
    begin
        mode_next = mode_step;
        off_next  = off_reg + OFF_ONE;
        sat_next  = sat_reg;
        if (byte_reg == CH_NUL)
        begin
            mode_next = MODE_IDLE;
            off_next  = '0;
            sat_next  = 1'b0;
        end
        else if (at_max)
        begin
            off_next = off_reg;
            sat_next = 1'b1;
        end
    end

    assign idle_out = run_idle && id_emit;

    always_comb
    begin
        main_tok.token_kind      = main_kind;
        main_tok.token_offset    = TOK_W'(ts_reg);
        main_tok.token_length    = main_len;
        main_tok.bool_value      = main_bool;
        main_tok.offset_overflow = sat_reg;
        main_tok.last_of_run     = !idle_out;

        idle_tok.token_kind      = id_kind;
        idle_tok.token_offset    = TOK_W'(off_reg);
        idle_tok.token_length    = id_len;
        idle_tok.bool_value      = 1'b0;
        idle_tok.offset_overflow = sat_reg;
        idle_tok.last_of_run     = 1'b1;

        res.tok[0] = main_emit ? main_tok : idle_tok;
        res.tok[1] = idle_tok;
        res.cnt    = vld_reg ? {main_emit & idle_out, main_emit ^ idle_out} : 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= text_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            mode_reg <= MODE_IDLE;
            off_reg  <= '0;
            ts_reg   <= '0;
            lk_reg   <= LIT_TRUE;
            li_reg   <= 3'd0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= load;
            if (vld_reg)
            begin
                mode_reg <= mode_next;
                off_reg  <= off_next;
                ts_reg   <= ts_next;
                lk_reg   <= lk_next;
                li_reg   <= li_next;
                sat_reg  <= sat_next;
            end
        end
    end

endmodule
